// ===== hw/rtl/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared constants and types of the sensor frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

   localparam int FRAME_BYTES_DEF = 32;
   localparam int DATA_WORDS_DEF  = 12;

   localparam int RX_W    = 8;
   localparam int CSR_W   = 16;
   localparam int STAT_W  = 2;
   localparam int INDEX_W = 4;
   localparam int WORD_W  = 16;
   localparam int RSP_W   = 24;

   typedef logic [1:0] csr_addr_type;
   localparam csr_addr_type CSR_START_ONE = 2'd0;
   localparam csr_addr_type CSR_START_TWO = 2'd1;
   localparam csr_addr_type CSR_LENGTH    = 2'd2;

   localparam logic [7:0]  START_ONE_RST = 8'd66;
   localparam logic [7:0]  START_TWO_RST = 8'd77;
   localparam logic [15:0] LENGTH_RST    = 16'd28;

   typedef logic [STAT_W-1:0] status_type;
   localparam status_type ST_DATA    = 2'd0;
   localparam status_type ST_BAD_LEN = 2'd1;
   localparam status_type ST_BAD_SUM = 2'd2;

   typedef struct packed {
      logic start_one;
      logic start_two;
      logic body;
      logic load_err;
      logic load_word;
   } sfp_cmd_type;

   typedef struct packed {
      logic match_one;
      logic match_two;
      logic final_byte;
      logic frame_bad;
      logic out_free;
      logic emit_last;
   } sfp_stat_type;

endpackage

// ===== hw/rtl/sensor_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_parser
// Sum-checksum serial frame parser: syncs on two start bytes, checks length
// and checksum, emits the frame's data words or one error item.
// ----------------------------------------------------------------------------
//  channel  direction  content
//  req_     in         tdata[7:0] rx_byte
//  rsp_     out        tdata status, word_index, word_value; tlast = last
//  csr_     in         write enable, register index, 16-bit data
//
//  One byte is taken per cycle; the frame's last byte is held off only while
//  the output register is full and not draining.
//  A good frame then emits DATA_WORDS words from the word store, one per
//  cycle while the output register is free, with req_tready low.
//  Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
module sensor_frame_parser #(
   parameter int FRAME_BYTES = sfp_pkg::FRAME_BYTES_DEF,
   parameter int DATA_WORDS  = sfp_pkg::DATA_WORDS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [sfp_pkg::RX_W-1:0]   req_tdata,   // [7:0] rx_byte
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [sfp_pkg::RSP_W-1:0]  rsp_tdata,   // [1:0] status, [5:2] word_index,
                                                   // [21:6] word_value
   output logic                      rsp_tlast,
   input  logic                      csr_wen,
   input  sfp_pkg::csr_addr_type      csr_addr,
   input  logic [sfp_pkg::CSR_W-1:0]  csr_wdata
);

   sfp_pkg::sfp_cmd_type  cmd;
   sfp_pkg::sfp_stat_type stat;

   sfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfp_dpath #(
      .FRAME_BYTES (FRAME_BYTES),
      .DATA_WORDS  (DATA_WORDS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/sfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfp_ctrl
// Frame sync state machine: hunts start bytes, walks the body, drives the
// word emission sequence.
// ----------------------------------------------------------------------------
module sfp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sfp_pkg::sfp_stat_type stat,
   output sfp_pkg::sfp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_HUNT_ONE,
      S_HUNT_TWO,
      S_BODY,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   always_comb begin
      case (state_ff)
         S_BODY:  req_tready = !stat.final_byte || stat.out_free;
         S_EMIT:  req_tready = 1'b0;
         default: req_tready = 1'b1;
      endcase
   end

   assign take = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_HUNT_ONE: begin
            if (take && stat.match_one) begin
               cmd.start_one = 1'b1;
               state_in      = S_HUNT_TWO;
            end
         end
         S_HUNT_TWO: begin
            if (take) begin
               if (stat.match_two) begin
                  cmd.start_two = 1'b1;
                  state_in      = S_BODY;
               end else begin
                  state_in = S_HUNT_ONE;
               end
            end
         end
         S_BODY: begin
            if (take) begin
               cmd.body = 1'b1;
               if (stat.final_byte) begin
                  if (stat.frame_bad) begin
                     cmd.load_err = 1'b1;
                     state_in     = S_HUNT_ONE;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.load_word = 1'b1;
               if (stat.emit_last) begin
                  state_in = S_HUNT_ONE;
               end
            end
         end
         default: state_in = S_HUNT_ONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT_ONE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/sfp_dpath.sv =====
// ----------------------------------------------------------------------------
// sfp_dpath
// Byte counter, running sum, length and word capture, config registers and
// the result output register.
// ----------------------------------------------------------------------------
module sfp_dpath #(
   parameter int FRAME_BYTES = sfp_pkg::FRAME_BYTES_DEF,
   parameter int DATA_WORDS  = sfp_pkg::DATA_WORDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sfp_pkg::sfp_cmd_type        cmd,
   output sfp_pkg::sfp_stat_type       stat,
   input  logic [sfp_pkg::RX_W-1:0]    req_tdata,
   input  logic                       csr_wen,
   input  sfp_pkg::csr_addr_type       csr_addr,
   input  logic [sfp_pkg::CSR_W-1:0]   csr_wdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [sfp_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int CNT_W  = $clog2(FRAME_BYTES);
   localparam int EXT_W  = CNT_W + 4;
   localparam int SIDX_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
   localparam int AVAIL  = (FRAME_BYTES - 6) / 2;
   localparam int KEXT_W = 6;

   localparam logic [CNT_W-1:0]  LEN_HI_POS = CNT_W'(2);
   localparam logic [CNT_W-1:0]  LEN_LO_POS = CNT_W'(3);
   localparam logic [CNT_W-1:0]  DATA_POS   = CNT_W'(4);
   localparam logic [CNT_W-1:0]  SUM_END    = CNT_W'(FRAME_BYTES - 2);
   localparam logic [CNT_W-1:0]  LAST_POS   = CNT_W'(FRAME_BYTES - 1);
   localparam logic [EXT_W-1:0]  WORDS_EXT  = EXT_W'(DATA_WORDS);
   localparam logic [3:0]        K_LAST     = 4'(DATA_WORDS - 1);
   localparam logic [KEXT_W-1:0] AVAIL_EXT  = KEXT_W'(AVAIL);

   logic [7:0]             start_one_ff, start_one_in;
   logic [7:0]             start_two_ff, start_two_in;
   logic [15:0]            exp_len_ff, exp_len_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [15:0]            sum_ff, sum_in;
   logic [15:0]            length_ff, length_in;
   logic [7:0]             high_ff, high_in;
   logic [3:0]             k_ff, k_in;
   logic                   valid_ff, valid_in;
   logic [sfp_pkg::RSP_W-1:0] data_ff, data_in;
   logic                   last_ff, last_in;
   logic [15:0]            store_ff [DATA_WORDS];

   logic [7:0]             rx;
   logic                   in_data;
   logic [EXT_W-1:0]       widx;
   logic                   store_we;
   logic [15:0]            recv;
   logic                   len_bad;
   logic [15:0]            word_out;
   sfp_pkg::status_type    err_code;

   assign rx       = req_tdata;
   assign in_data  = (count_ff >= DATA_POS) && (count_ff < SUM_END);
   assign widx     = (EXT_W'(count_ff) - EXT_W'(4)) >> 1;
   assign store_we = cmd.body && in_data && count_ff[0] && (widx < WORDS_EXT);
   assign recv     = {high_ff, rx};
   assign len_bad  = length_ff != exp_len_ff;
   assign err_code = len_bad ? sfp_pkg::ST_BAD_LEN : sfp_pkg::ST_BAD_SUM;
   assign word_out = ({2'b00, k_ff} < AVAIL_EXT) ? store_ff[k_ff[SIDX_W-1:0]] : 16'd0;

   assign stat.match_one  = rx == start_one_ff;
   assign stat.match_two  = rx == start_two_ff;
   assign stat.final_byte = count_ff == LAST_POS;
   assign stat.frame_bad  = len_bad || (sum_ff != recv);
   assign stat.out_free   = !valid_ff || rsp_tready;
   assign stat.emit_last  = k_ff == K_LAST;

   always_comb begin
      start_one_in = start_one_ff;
      start_two_in = start_two_ff;
      exp_len_in   = exp_len_ff;
      if (csr_wen) begin
         case (csr_addr)
            sfp_pkg::CSR_START_ONE: start_one_in = csr_wdata[7:0];
            sfp_pkg::CSR_START_TWO: start_two_in = csr_wdata[7:0];
            sfp_pkg::CSR_LENGTH:    exp_len_in   = csr_wdata;
            default:                ;
         endcase
      end
   end

   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      length_in = length_ff;
      high_in   = high_ff;
      if (cmd.start_one) begin
         sum_in   = {8'd0, rx};
         count_in = CNT_W'(1);
      end else if (cmd.start_two) begin
         sum_in   = sum_ff + {8'd0, rx};
         count_in = CNT_W'(2);
      end else if (cmd.body) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff < SUM_END) begin
            sum_in = sum_ff + {8'd0, rx};
         end
         if (count_ff == LEN_LO_POS) begin
            length_in = recv;
         end
         if (count_ff == LEN_HI_POS || count_ff == SUM_END || (in_data && !count_ff[0])) begin
            high_in = rx;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      k_in     = k_ff;
      if (cmd.load_err) begin
         valid_in = 1'b1;
         data_in  = {2'b00, 16'd0, 4'd0, err_code};
         last_in  = 1'b1;
      end else if (cmd.load_word) begin
         valid_in = 1'b1;
         data_in  = {2'b00, word_out, k_ff, sfp_pkg::ST_DATA};
         last_in  = stat.emit_last;
         k_in     = stat.emit_last ? 4'd0 : k_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_one_ff <= sfp_pkg::START_ONE_RST;
         start_two_ff <= sfp_pkg::START_TWO_RST;
         exp_len_ff   <= sfp_pkg::LENGTH_RST;
         count_ff     <= '0;
         sum_ff       <= '0;
         length_ff    <= '0;
         high_ff      <= '0;
         k_ff         <= '0;
         valid_ff     <= 1'b0;
      end else begin
         start_one_ff <= start_one_in;
         start_two_ff <= start_two_in;
         exp_len_ff   <= exp_len_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         length_ff    <= length_in;
         high_ff      <= high_in;
         k_ff         <= k_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      if (store_we) begin
         store_ff[widx[SIDX_W-1:0]] <= recv;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== hw/rtl/sfp_checker.sv =====
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks of the frame parser result channel.
// ----------------------------------------------------------------------------
module sfp_checker #(
   parameter int DATA_WORDS = sfp_pkg::DATA_WORDS_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [sfp_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                      rsp_tlast
);

   localparam logic [3:0] K_LAST = 4'(DATA_WORDS - 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != sfp_pkg::ST_DATA |->
         rsp_tlast && rsp_tdata[21:2] == 20'd0)
      else $error("error item not last or not zero");

   a_word_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == sfp_pkg::ST_DATA |->
         rsp_tlast == (rsp_tdata[5:2] == K_LAST))
      else $error("last flag mismatches word index");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid |->
         rsp_tdata[1:0] == sfp_pkg::ST_DATA &&
         rsp_tdata[5:2] == $past(rsp_tdata[5:2]) + 4'd1)
      else $error("word items out of order");

endmodule

bind sensor_frame_parser sfp_checker #(.DATA_WORDS(DATA_WORDS)) u_sfp_checker (.*);
